// File: design/pid_controller_step_defines.svh
// Assertion macros for the pid_controller_step checker.
// Depends on nothing; included by pid_checker.sv.
`ifndef PID_CONTROLLER_STEP_DEFINES_SVH
`define PID_CONTROLLER_STEP_DEFINES_SVH

// Consequent checked in the cycle after the antecedent.
`define PID_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("pid_checker: next-cycle property failed");

// Consequent checked in the same cycle as the antecedent.
`define PID_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("pid_checker: same-cycle property failed");

`endif

// File: design/pid_pkg.sv
// Shared types and constants for the PID controller step block.
// No dependencies; used by pid_mdu, pid_controller_step and pid_checker.
package pid_pkg;

  localparam int DATA_WIDTH    = 32;
  localparam int TIME_WIDTH    = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ACC_WIDTH_DEF = 64;
  localparam int DIGIT_W       = 8;
  localparam int CFG_INDEX_W   = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_PROP     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_INTEG    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_DERIV    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL_MODE = 2'd3;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] error_sample;
    logic        [TIME_WIDTH-1:0] time_value;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] drive;
    logic                         out_saturated;
    logic                         zero_interval;
  } out_req_t;

  typedef struct packed {
    logic mul_go;
    logic div_go;
    logic neg;
  } mdu_cmd_t;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_MUL_EDT = 9'b000000010,
    ST_INTEG   = 9'b000000100,
    ST_DIV     = 9'b000001000,
    ST_MUL_P   = 9'b000010000,
    ST_MUL_I   = 9'b000100000,
    ST_MUL_D   = 9'b001000000,
    ST_OUT     = 9'b010000000,
    ST_SPARE   = 9'b100000000
  } seq_state_t;

endpackage

// File: design/pid_mdu.sv
// Iterative multiply/divide unit: magnitude operands, one shared adder.
// Depends on pid_pkg (mdu_cmd_t, DIGIT_W, TIME_WIDTH).
module pid_mdu #(
  parameter int AW  = pid_pkg::ACC_WIDTH_DEF,
  parameter int BW  = pid_pkg::DATA_WIDTH,
  parameter int DVW = pid_pkg::DATA_WIDTH
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  pid_pkg::mdu_cmd_t                                   cmd,
  input  logic [AW-1:0]                                       a_mag,
  input  logic [BW-1:0]                                       b_mag,
  output logic                                                done,
  output logic [AW+((BW+pid_pkg::DIGIT_W-1)/pid_pkg::DIGIT_W)*pid_pkg::DIGIT_W:0] result
);

  localparam int DGW  = pid_pkg::DIGIT_W;
  localparam int TMW  = pid_pkg::TIME_WIDTH;
  localparam int NDIG = (BW + DGW - 1) / DGW;
  localparam int BPW  = NDIG * DGW;
  localparam int RW   = AW + BPW + 1;
  localparam int MAXS = (NDIG > DVW) ? NDIG : DVW;
  localparam int CNT_W = $clog2(MAXS);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_MUL  = 4'b0010,
    PH_DIV  = 4'b0100,
    PH_FIX  = 4'b1000
  } mdu_phase_t;

  mdu_phase_t         ph_r, ph_nxt;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [AW-1:0]      a_r;
  logic [BPW-1:0]     b_r;
  logic [AW-1:0]      hi_r;
  logic [BPW-1:0]     lo_r;
  logic [TMW-1:0]     rem_r;
  logic [TMW-1:0]     dv_r;
  logic [DVW-1:0]     quo_r;
  logic               neg_r;
  logic               is_mul_r;
  logic [RW-1:0]      result_r;

  logic [AW+DGW-1:0]  pp;
  logic [TMW:0]       trial;
  logic [RW-1:0]      fix_src;
  logic [RW-1:0]      add_x, add_y, add_s;
  logic               add_ci;
  logic               ge;

  // one digit partial product: AW x 8
  assign pp    = {{DGW{1'b0}}, a_r} * {{AW{1'b0}}, b_r[DGW-1:0]};
  assign trial = {rem_r, quo_r[DVW-1]};
  assign fix_src = is_mul_r ? {1'b0, hi_r, lo_r} : RW'(quo_r);

  // shared adder
  always_comb begin
    add_x  = '0;
    add_y  = '0;
    add_ci = 1'b0;
    unique case (ph_r)
      PH_MUL: begin
        add_x = RW'(hi_r);
        add_y = RW'(pp);
      end
      PH_DIV: begin
        add_x  = RW'(trial);
        add_y  = ~RW'(dv_r);
        add_ci = 1'b1;
      end
      PH_FIX: begin
        add_y  = ~fix_src;
        add_ci = 1'b1;
      end
      default: add_ci = 1'b0;
    endcase
  end

  assign add_s = add_x + add_y + RW'(add_ci);
  assign ge    = ~add_s[RW-1];

  always_comb begin
    ph_nxt = ph_r;
    unique case (ph_r)
      PH_IDLE: begin
        if (cmd.mul_go) begin
          ph_nxt = PH_MUL;
        end else if (cmd.div_go) begin
          ph_nxt = PH_DIV;
        end
      end
      PH_MUL:  if (cnt_r == '0) ph_nxt = PH_FIX;
      PH_DIV:  if (cnt_r == '0) ph_nxt = PH_FIX;
      PH_FIX:  ph_nxt = PH_IDLE;
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= (ph_r == PH_FIX);
    end
  end

  always_ff @(posedge clk) begin
    unique case (ph_r)
      PH_IDLE: begin
        neg_r <= cmd.neg;
        if (cmd.mul_go) begin
          a_r      <= a_mag;
          b_r      <= BPW'(b_mag);
          hi_r     <= '0;
          lo_r     <= '0;
          cnt_r    <= CNT_W'(NDIG - 1);
          is_mul_r <= 1'b1;
        end else if (cmd.div_go) begin
          rem_r    <= '0;
          quo_r    <= a_mag[DVW-1:0];
          dv_r     <= b_mag[TMW-1:0];
          cnt_r    <= CNT_W'(DVW - 1);
          is_mul_r <= 1'b0;
        end
      end
      PH_MUL: begin
        hi_r  <= add_s[AW+DGW-1:DGW];
        lo_r  <= {add_s[DGW-1:0], lo_r[BPW-1:DGW]};
        b_r   <= b_r >> DGW;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      PH_DIV: begin
        // restoring step, one quotient bit
        rem_r <= ge ? add_s[TMW-1:0] : trial[TMW-1:0];
        quo_r <= {quo_r[DVW-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
      end
      PH_FIX: begin
        result_r <= neg_r ? add_s : fix_src;
      end
      default: neg_r <= 1'b0;
    endcase
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

// File: design/pid_controller_step.sv
// Top level of the fixed-point PID controller step.
// Depends on pid_pkg and pid_mdu.
//
// Each input request brings an error sample (signed Q16.16) and a time value in
// ticks. With interval_mode 0 the time value is a timestamp and the interval is
// its difference from the stored timestamp, modulo 2^32; with interval_mode 1
// it is the interval itself. The block adds error*interval to a saturating
// ACC_WIDTH-bit integral, divides the change in error by the interval (truncated
// toward zero; derivative forced to zero and zero_interval set when the
// interval is zero) and returns P+I+D saturated to 32 bits, with out_saturated
// set when the integral or the output was clipped. Products are shifted right
// by FRAC_BITS with floor rounding before the exact sum. One request is worked
// at a time, by the shared multiply/divide unit: a one-bit-per-cycle restoring
// divide and four multiplies over 8-bit digits, the divide skipped when the
// interval is zero. in_stall is high from acceptance until the result is loaded;
// a result waiting on out_stall does not block the next request from being
// accepted. Configuration writes apply at once.
module pid_controller_step #(
  parameter int FRAC_BITS = pid_pkg::FRAC_BITS_DEF,
  parameter int ACC_WIDTH = pid_pkg::ACC_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pid_pkg::in_req_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pid_pkg::out_req_t                   out_data,
  input  logic                                cfg_we,
  input  logic [pid_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pid_pkg::DATA_WIDTH-1:0]      cfg_wdata
);

  localparam int DW   = pid_pkg::DATA_WIDTH;
  localparam int TMW  = pid_pkg::TIME_WIDTH;
  localparam int DGW  = pid_pkg::DIGIT_W;
  localparam int AW   = (ACC_WIDTH > DW) ? ACC_WIDTH : DW;
  localparam int BW   = (DW > TMW) ? DW : TMW;
  localparam int NDIG = (BW + DGW - 1) / DGW;
  localparam int RW   = AW + NDIG * DGW + 1;   // signed product width
  localparam int ISW  = RW + 1;                // integral sum width
  localparam int TSW  = RW + 2;                // P+I+D sum width

  localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic [DW-1:0]        DRV_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0]        DRV_MIN = {1'b1, {(DW-1){1'b0}}};

  // configuration
  logic [DW-1:0]        gp_r, gp_nxt, gi_r, gi_nxt, gd_r, gd_nxt;
  logic                 mode_r, mode_nxt;
  // controller state
  logic [ACC_WIDTH-1:0] acc_r, acc_nxt;
  logic [DW-1:0]        prev_err_r, prev_err_nxt;
  logic [TMW-1:0]       prev_stamp_r, prev_stamp_nxt;
  // sequencer
  pid_pkg::seq_state_t  state_r, state_nxt;
  logic                 mul_go_r, mul_go_nxt, div_go_r, div_go_nxt;
  logic                 out_valid_r, out_valid_nxt;
  // per-request working registers
  logic [DW-1:0]        e_r, e_nxt;
  logic [TMW-1:0]       dt_r, dt_nxt;
  logic                 zero_r, zero_nxt;
  logic [DW:0]          deriv_r, deriv_nxt;
  logic [TSW-1:0]       tot_r, tot_nxt;
  logic                 clip_r, clip_nxt;
  pid_pkg::out_req_t    out_data_r, out_data_nxt;

  logic                 in_accept;
  logic [TMW-1:0]       dt_in;
  logic [DW-1:0]        e_mag, gp_mag, gi_mag, gd_mag;
  logic [ACC_WIDTH-1:0] acc_mag;
  logic [DW:0]          deriv_neg, diff, diff_neg;
  logic [DW-1:0]        deriv_mag, diff_mag;
  logic [AW-1:0]        op_a;
  logic [BW-1:0]        op_b;
  logic                 op_neg;
  pid_pkg::mdu_cmd_t    mdu_cmd;
  logic                 mdu_done;
  logic [RW-1:0]        mdu_res;
  logic [ISW-1:0]       isum;
  logic                 ifits;
  logic [ACC_WIDTH-1:0] isat;
  logic [TSW-1:0]       term;
  logic                 dfits;
  logic [DW-1:0]        drive_sat;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != pid_pkg::ST_IDLE);
  assign dt_in     = mode_r ? in_data.time_value : (in_data.time_value - prev_stamp_r);

  // magnitudes for the sign-magnitude unit
  assign e_mag     = e_r[DW-1] ? (~e_r + DW'(1)) : e_r;
  assign gp_mag    = gp_r[DW-1] ? (~gp_r + DW'(1)) : gp_r;
  assign gi_mag    = gi_r[DW-1] ? (~gi_r + DW'(1)) : gi_r;
  assign gd_mag    = gd_r[DW-1] ? (~gd_r + DW'(1)) : gd_r;
  assign acc_mag   = acc_r[ACC_WIDTH-1] ? (~acc_r + ACC_WIDTH'(1)) : acc_r;
  assign deriv_neg = ~deriv_r + (DW+1)'(1);
  assign deriv_mag = deriv_r[DW] ? deriv_neg[DW-1:0] : deriv_r[DW-1:0];
  // error change never exceeds DW bits of magnitude
  assign diff      = {e_r[DW-1], e_r} - {prev_err_r[DW-1], prev_err_r};
  assign diff_neg  = ~diff + (DW+1)'(1);
  assign diff_mag  = diff[DW] ? diff_neg[DW-1:0] : diff[DW-1:0];

  // operands follow the state the unit is started in
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_neg = 1'b0;
    unique case (state_r)
      pid_pkg::ST_MUL_EDT: begin
        op_a   = AW'(e_mag);
        op_b   = BW'(dt_r);
        op_neg = e_r[DW-1];
      end
      pid_pkg::ST_DIV: begin
        op_a   = AW'(diff_mag);
        op_b   = BW'(dt_r);
        op_neg = diff[DW];
      end
      pid_pkg::ST_MUL_P: begin
        op_a   = AW'(e_mag);
        op_b   = BW'(gp_mag);
        op_neg = e_r[DW-1] ^ gp_r[DW-1];
      end
      pid_pkg::ST_MUL_I: begin
        op_a   = AW'(acc_mag);
        op_b   = BW'(gi_mag);
        op_neg = acc_r[ACC_WIDTH-1] ^ gi_r[DW-1];
      end
      pid_pkg::ST_MUL_D: begin
        op_a   = AW'(deriv_mag);
        op_b   = BW'(gd_mag);
        op_neg = deriv_r[DW] ^ gd_r[DW-1];
      end
      default: op_neg = 1'b0;
    endcase
  end

  assign mdu_cmd = '{mul_go: mul_go_r, div_go: div_go_r, neg: op_neg};

  pid_mdu #(
    .AW  (AW),
    .BW  (BW),
    .DVW (DW)
  ) u_mdu (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (mdu_cmd),
    .a_mag  (op_a),
    .b_mag  (op_b),
    .done   (mdu_done),
    .result (mdu_res)
  );

  // integral update and clip
  assign isum  = {mdu_res[RW-1], mdu_res} + {{(ISW-ACC_WIDTH){acc_r[ACC_WIDTH-1]}}, acc_r};
  assign ifits = (&isum[ISW-1:ACC_WIDTH-1]) | ~(|isum[ISW-1:ACC_WIDTH-1]);
  assign isat  = ifits ? isum[ACC_WIDTH-1:0] : (isum[ISW-1] ? ACC_MIN : ACC_MAX);

  // floor shift of the current product
  assign term  = {{(FRAC_BITS+2){mdu_res[RW-1]}}, mdu_res[RW-1:FRAC_BITS]};

  // output clip
  assign dfits     = (&tot_r[TSW-1:DW-1]) | ~(|tot_r[TSW-1:DW-1]);
  assign drive_sat = dfits ? tot_r[DW-1:0] : (tot_r[TSW-1] ? DRV_MIN : DRV_MAX);

  always_comb begin
    gp_nxt         = gp_r;
    gi_nxt         = gi_r;
    gd_nxt         = gd_r;
    mode_nxt       = mode_r;
    acc_nxt        = acc_r;
    prev_err_nxt   = prev_err_r;
    prev_stamp_nxt = prev_stamp_r;
    state_nxt      = state_r;
    mul_go_nxt     = 1'b0;
    div_go_nxt     = 1'b0;
    out_valid_nxt  = out_valid_r && out_stall;
    e_nxt          = e_r;
    dt_nxt         = dt_r;
    zero_nxt       = zero_r;
    deriv_nxt      = deriv_r;
    tot_nxt        = tot_r;
    clip_nxt       = clip_r;
    out_data_nxt   = out_data_r;

    if (cfg_we) begin
      unique case (cfg_index)
        pid_pkg::REG_GAIN_PROP:     gp_nxt   = cfg_wdata;
        pid_pkg::REG_GAIN_INTEG:    gi_nxt   = cfg_wdata;
        pid_pkg::REG_GAIN_DERIV:    gd_nxt   = cfg_wdata;
        pid_pkg::REG_INTERVAL_MODE: mode_nxt = cfg_wdata[0];
      endcase
    end

    unique case (state_r)
      pid_pkg::ST_IDLE: begin
        if (in_accept) begin
          e_nxt    = in_data.error_sample;
          dt_nxt   = dt_in;
          zero_nxt = (dt_in == '0);
          if (!mode_r) prev_stamp_nxt = in_data.time_value;
          state_nxt  = pid_pkg::ST_MUL_EDT;
          mul_go_nxt = 1'b1;
        end
      end
      pid_pkg::ST_MUL_EDT: begin
        if (mdu_done) state_nxt = pid_pkg::ST_INTEG;
      end
      pid_pkg::ST_INTEG: begin
        acc_nxt  = isat;
        clip_nxt = !ifits;
        if (zero_r) begin
          // no divide: derivative term is zero
          deriv_nxt  = '0;
          state_nxt  = pid_pkg::ST_MUL_P;
          mul_go_nxt = 1'b1;
        end else begin
          state_nxt  = pid_pkg::ST_DIV;
          div_go_nxt = 1'b1;
        end
      end
      pid_pkg::ST_DIV: begin
        if (mdu_done) begin
          deriv_nxt  = mdu_res[DW:0];
          state_nxt  = pid_pkg::ST_MUL_P;
          mul_go_nxt = 1'b1;
        end
      end
      pid_pkg::ST_MUL_P: begin
        if (mdu_done) begin
          tot_nxt      = term;
          prev_err_nxt = e_r;
          state_nxt    = pid_pkg::ST_MUL_I;
          mul_go_nxt   = 1'b1;
        end
      end
      pid_pkg::ST_MUL_I: begin
        if (mdu_done) begin
          tot_nxt    = tot_r + term;
          state_nxt  = pid_pkg::ST_MUL_D;
          mul_go_nxt = 1'b1;
        end
      end
      pid_pkg::ST_MUL_D: begin
        if (mdu_done) begin
          tot_nxt   = tot_r + term;
          state_nxt = pid_pkg::ST_OUT;
        end
      end
      pid_pkg::ST_OUT: begin
        // load once the output register is free or being emptied
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.drive         = drive_sat;
          out_data_nxt.out_saturated = clip_r | !dfits;
          out_data_nxt.zero_interval = zero_r;
          out_valid_nxt              = 1'b1;
          state_nxt                  = pid_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pid_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gp_r         <= '0;
      gi_r         <= '0;
      gd_r         <= '0;
      mode_r       <= 1'b0;
      acc_r        <= '0;
      prev_err_r   <= '0;
      prev_stamp_r <= '0;
      state_r      <= pid_pkg::ST_IDLE;
      mul_go_r     <= 1'b0;
      div_go_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      gp_r         <= gp_nxt;
      gi_r         <= gi_nxt;
      gd_r         <= gd_nxt;
      mode_r       <= mode_nxt;
      acc_r        <= acc_nxt;
      prev_err_r   <= prev_err_nxt;
      prev_stamp_r <= prev_stamp_nxt;
      state_r      <= state_nxt;
      mul_go_r     <= mul_go_nxt;
      div_go_r     <= div_go_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r        <= e_nxt;
    dt_r       <= dt_nxt;
    zero_r     <= zero_nxt;
    deriv_r    <= deriv_nxt;
    tot_r      <= tot_nxt;
    clip_r     <= clip_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/pid_checker.sv
// Port-level checker for pid_controller_step, attached by bind.
// Depends on pid_pkg and pid_controller_step_defines.svh.
`include "pid_controller_step_defines.svh"

module pid_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input pid_pkg::out_req_t out_data
);

  // stalled result holds
  `PID_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  // one request at a time
  `PID_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // no result shows up the cycle after a request is taken
  `PID_ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_valid && !in_stall, !$rose(out_valid))
  // a fresh result means the sequencer is back to idle
  `PID_ASSERT_SAME(a_result_frees_input, clk, rst_n, $rose(out_valid), !in_stall)

endmodule

bind pid_controller_step pid_checker u_pid_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
